// ----- rtl/sha256_byte_stream_hasher_defines.svh -----
// Assertion macros shared by the SHA-256 hasher checker.
// No dependencies.
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define SHB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define SHB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- rtl/shb_pkg.sv -----
// Package for the SHA-256 byte-stream hasher: constants, types, round functions.
// No dependencies.
package shb_pkg;
    localparam int QDepth = 4;

    typedef logic [31:0] t_word;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       message_end;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_COMP,
        ST_ADD,
        ST_EMIT
    } t_state;

    function automatic t_word round_k(input logic [5:0] i);
        t_word k;
        case (i)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic t_word init_h(input logic [2:0] i);
        t_word h;
        case (i)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic t_word ror(input t_word x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction
endpackage

// ----- rtl/shb_front.sv -----
// Front end: input skid-free queue of accepted stream items.
// Depends on shb_pkg.
module shb_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  shb_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output shb_pkg::t_item o_item
);
    import shb_pkg::*;
    localparam int AW = $clog2(QDepth);

    t_item          r_mem [QDepth];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_cnt;
    logic           w_push, w_pop;

    assign o_ready = (r_cnt != (AW+1)'(QDepth));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    // Drop idle items here; they change nothing.
    assign w_push  = i_valid && o_ready && (i_item.has_byte || i_item.message_end);
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
    end
endmodule

// ----- rtl/shb_back.sv -----
// Back end: block buffer, padding sequencer, one-round-per-cycle compression.
// Depends on shb_pkg.
module shb_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  shb_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [31:0]    o_word,
    output logic [2:0]     o_index,
    output logic           o_last
);
    import shb_pkg::*;

    t_state      r_state, n_state;
    t_word       r_h [8];
    t_word       r_v [8];
    t_word       r_w [16];
    logic [63:0] r_bits;
    logic [5:0]  r_pos;
    logic [5:0]  r_rnd;
    logic        r_fin;    // message end taken, digest still owed
    logic        r_mark;   // 0x80 marker already written
    logic        r_lenw;   // length words written: digest follows this block
    logic [2:0]  r_oi;

    logic        w_take, w_full, w_wr;
    logic [7:0]  w_byte;
    t_word       w_wt, w_s0, w_s1, w_t1, w_t2, w_ins;
    t_word       w_e, w_a;

    assign o_ready = (r_state == ST_IDLE);
    assign w_take  = i_valid && o_ready;
    assign o_valid = (r_state == ST_EMIT);
    assign o_word  = r_h[r_oi];
    assign o_index = r_oi;
    assign o_last  = (r_oi == 3'd7);
    assign w_full  = (r_pos == 6'd63);

    // Message schedule: window of 16 words, shifted each round.
    assign w_s0 = ror(r_w[1], 7) ^ ror(r_w[1], 18) ^ (r_w[1] >> 3);
    assign w_s1 = ror(r_w[14], 17) ^ ror(r_w[14], 19) ^ (r_w[14] >> 10);
    assign w_wt = r_w[0];
    assign w_e  = r_v[4];
    assign w_a  = r_v[0];
    assign w_t1 = r_v[7] + (ror(w_e, 6) ^ ror(w_e, 11) ^ ror(w_e, 25))
                + ((w_e & r_v[5]) ^ (~w_e & r_v[6])) + round_k(r_rnd) + w_wt;
    assign w_t2 = (ror(w_a, 2) ^ ror(w_a, 13) ^ ror(w_a, 22))
                + ((w_a & r_v[1]) ^ (w_a & r_v[2]) ^ (r_v[1] & r_v[2]));

    // Byte value written at r_pos: message byte, or pad.
    always_comb begin
        w_byte = 8'h00;
        w_wr   = 1'b0;
        if (w_take && i_item.has_byte) begin
            w_byte = i_item.data_byte;
            w_wr   = 1'b1;
        end else if (r_state == ST_PAD) begin
            w_byte = r_mark ? 8'h00 : 8'h80;
            w_wr   = 1'b1;
        end
        w_ins = r_w[r_pos[5:2]];
        case (r_pos[1:0])
            2'd0: w_ins = {w_byte, 24'h0};
            2'd1: w_ins[23:16] = w_byte;
            2'd2: w_ins[15:8] = w_byte;
            default: w_ins[7:0] = w_byte;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    if (i_item.has_byte && w_full) n_state = ST_COMP;
                    else if (i_item.message_end) n_state = ST_PAD;
                end
            end
            ST_PAD: begin
                if (w_full) n_state = ST_COMP;
                else if (r_pos == 6'd55) n_state = ST_LEN;
            end
            ST_LEN:  n_state = ST_COMP;
            ST_COMP: begin
                if (r_rnd == 6'd63) n_state = ST_ADD;
            end
            ST_ADD: begin
                if (r_lenw) n_state = ST_EMIT;
                else if (r_fin) n_state = ST_PAD;
                else n_state = ST_IDLE;
            end
            ST_EMIT: begin
                if (i_ready && o_last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
            r_pos  <= '0;
            r_rnd  <= '0;
            r_fin  <= 1'b0;
            r_mark <= 1'b0;
            r_lenw <= 1'b0;
            r_oi   <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= init_h(3'(i));
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_wr) begin
                        r_w[r_pos[5:2]] <= w_ins;
                        r_pos <= r_pos + 6'd1;
                    end
                    if (w_take && i_item.has_byte) r_bits <= r_bits + 64'd8;
                    if (w_take && i_item.message_end) r_fin <= 1'b1;
                end
                ST_PAD: begin
                    r_w[r_pos[5:2]] <= w_ins;
                    r_pos  <= r_pos + 6'd1;
                    r_mark <= 1'b1;
                end
                ST_LEN: begin
                    r_w[14] <= r_bits[63:32];
                    r_w[15] <= r_bits[31:0];
                    r_pos   <= '0;
                    r_lenw  <= 1'b1;
                end
                ST_COMP: begin
                    r_rnd <= r_rnd + 6'd1;
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= w_s1 + r_w[9] + w_s0 + r_w[0];
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= w_e;
                    r_v[4] <= r_v[3] + w_t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= w_a;
                    r_v[0] <= w_t1 + w_t2;
                end
                ST_ADD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                end
                ST_EMIT: begin
                    if (i_ready) begin
                        r_oi <= r_oi + 3'd1;
                        if (r_oi == 3'd7) begin
                            for (int i = 0; i < 8; i++) r_h[i] <= init_h(3'(i));
                            r_bits <= '0;
                            r_fin  <= 1'b0;
                            r_mark <= 1'b0;
                            r_lenw <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
            // Load the working variables when a block starts compressing.
            if (n_state == ST_COMP && r_state != ST_COMP) begin
                r_rnd <= '0;
                for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
            end
        end
    end
endmodule

// ----- rtl/sha256_byte_stream_hasher.sv -----
// SHA-256 byte-stream hasher, top level; depends on shb_pkg, shb_front, shb_back.
// Path: a byte is registered in the front queue, then written into the block buffer while the
//   back end is idle; no byte is taken while a full block runs its rounds and feed-forward add.
// Message end: padding (spilling into a new block when the block already holds more than 55
//   bytes), the length words, compression and feed-forward add, then 8 digest word transfers.
// Reset: synchronous active-low i_rst_n loads the initial hash, clears count and queue.
module sha256_byte_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,   // message_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        m_axis_tlast    // last_word
);
    import shb_pkg::*;

    t_item w_in, w_q;
    logic  w_qv, w_qr;
    logic [31:0] w_word;
    logic [2:0]  w_idx;

    assign w_in = '{data_byte: s_axis_tdata, has_byte: s_axis_tuser[0],
                    message_end: s_axis_tlast};

    // Front: accept transfers into a short queue, drop items with neither flag.
    shb_front u_front (
        .i_clk, .i_rst_n, .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_item(w_in), .o_valid(w_qv), .i_ready(w_qr), .o_item(w_q)
    );

    // Back: take one byte per cycle while idle, hold the queue while padding, writing the
    // length, compressing, adding the block result or emitting the digest.
    shb_back u_back (
        .i_clk, .i_rst_n, .i_valid(w_qv), .o_ready(w_qr), .i_item(w_q),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_word(w_word), .o_index(w_idx), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {5'b0, w_idx, w_word};
endmodule

// ----- rtl/shb_checker.sv -----
// Port checker for the SHA-256 hasher, bound to the top level.
// Depends on sha256_byte_stream_hasher_defines.svh.
`include "sha256_byte_stream_hasher_defines.svh"
module shb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    logic [2:0]  w_idx;
    logic [40:0] w_out;
    logic        w_is7, w_stall, w_step;

    assign w_idx   = m_axis_tdata[34:32];
    assign w_out   = {m_axis_tlast, m_axis_tdata};
    assign w_is7   = (w_idx == 3'd7);
    assign w_stall = m_axis_tvalid && !m_axis_tready;
    assign w_step  = m_axis_tvalid && m_axis_tready && !m_axis_tlast;

    `SHB_ASSERT_IMP(a_last_idx, i_clk, i_rst_n, m_axis_tvalid, m_axis_tlast == w_is7, "last flag")
    `SHB_ASSERT_IMP(a_pad, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[39:35] == 5'd0, "pad bits")
    `SHB_ASSERT_NXT(a_hold, i_clk, i_rst_n, w_stall, m_axis_tvalid && $stable(w_out), "not held")
    `SHB_ASSERT_NXT(a_step, i_clk, i_rst_n, w_step, w_idx == $past(w_idx) + 3'd1, "index skip")
endmodule

bind sha256_byte_stream_hasher shb_checker u_chk (
    .i_clk, .i_rst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
);

// ----- verif/sha256_byte_stream_hasher_checker.sv -----
// Checker for the SHA-256 byte-stream hasher: predicts digests from input transfers.
// Depends on shb_pkg for the word type; compares output transfers in order.
`timescale 1ns / 100ps
module sha256_byte_stream_hasher_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic [0:0]  i_s_tuser,
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,
    input  logic        i_m_tlast,
    output int          o_fail_count,
    output int          o_pending
);
    import shb_pkg::*;

    localparam t_word RoundConst [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    localparam t_word StartHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    t_word       chain [8];
    t_word       blk [16];
    logic [63:0] msg_bits;
    logic [35:0] digest_q [$];   // {last_word, word_index, digest_word}
    int          fails = 0;
    int          pend = 0;

    assign o_fail_count = fails;
    assign o_pending    = pend;

    function automatic t_word rotr(t_word x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        t_word w [64];
        t_word v [8];
        t_word t1, t2;
        for (int i = 0; i < 16; i++) w[i] = blk[i];
        for (int i = 16; i < 64; i++) begin
            w[i] = w[i-16] + w[i-7]
                 + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
        end
        for (int i = 0; i < 8; i++) v[i] = chain[i];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain[i] += v[i];
    endtask

    // Place one byte big-endian in the block; compress once the block is full.
    task automatic place_byte(logic [5:0] pos, logic [7:0] b);
        t_word sh;
        sh = t_word'(b) << (24 - 8 * pos[1:0]);
        if (pos[1:0] == 2'd0) blk[pos[5:2]] = sh;
        else blk[pos[5:2]] |= sh;
        if (pos == 6'd63) compress_block();
    endtask

    task automatic absorb(logic [7:0] b, logic has, logic fin);
        logic [5:0]  pos;
        logic [63:0] len;
        if (has) begin
            place_byte(msg_bits[8:3], b);
            msg_bits += 64'd8;
        end
        if (fin) begin
            len = msg_bits;
            pos = len[8:3];
            place_byte(pos, 8'h80);
            pos++;
            while (pos != 6'd56) begin
                place_byte(pos, 8'h00);
                pos++;
            end
            blk[14] = len[63:32];
            blk[15] = len[31:0];
            compress_block();
            for (int i = 0; i < 8; i++)
                digest_q.insert(digest_q.size(), {(i == 7), 3'(i), chain[i]});
            for (int i = 0; i < 8; i++) chain[i] = StartHash[i];
            msg_bits = '0;
        end
    endtask

    always @(posedge i_clk) begin
        logic [35:0] want;
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) chain[i] = StartHash[i];
            msg_bits = '0;
            digest_q.delete();
            fails = 0;
        end else begin
            if (i_s_tvalid && i_s_tready) absorb(i_s_tdata, i_s_tuser[0], i_s_tlast);
            if (i_m_tvalid && i_m_tready) begin
                if (digest_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("mismatch: unexpected word %h last %b", i_m_tdata, i_m_tlast);
                end else begin
                    want = digest_q.pop_front();
                    if (i_m_tdata != {5'd0, want[34:0]} || i_m_tlast != want[35]) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: index %0d exp %h/%b got %h/%b",
                                     want[34:32], want[34:0], want[35], i_m_tdata, i_m_tlast);
                    end
                end
            end
        end
        pend = digest_q.size();
    end
endmodule

// ----- verif/tb_sha256_byte_stream_hasher.sv -----
// Testbench top for the SHA-256 byte-stream hasher: clock, reset, stimulus, verdict.
// Depends on sha256_byte_stream_hasher and sha256_byte_stream_hasher_checker.
`timescale 1ns / 100ps
module tb_sha256_byte_stream_hasher;
    localparam int IdleLimit  = 4000;
    localparam int ItemTarget = 320;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [7:0] data_byte
    logic [0:0]  s_axis_tuser = '0;    // [0] has_byte
    logic        s_axis_tlast = 1'b0;  // message_end
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // [31:0] digest_word, [34:32] word_index
    logic        m_axis_tlast;         // last_word
    int          fail_count, pending;
    int          items_sent = 0;
    int          idle_cycles = 0;
    bit          long_hold_done = 0;
    bit          sender_fast = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    sha256_byte_stream_hasher uut (.*);

    sha256_byte_stream_hasher_checker digest_chk (
        .i_clk, .i_rst_n,
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready),
        .i_s_tdata(s_axis_tdata), .i_s_tuser(s_axis_tuser), .i_s_tlast(s_axis_tlast),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready),
        .i_m_tdata(m_axis_tdata), .i_m_tlast(m_axis_tlast),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Offer one item after a random gap; hold it until the transfer.
    // Valid stays high across back-to-back items, so it is set once per step.
    task automatic send_item(logic [7:0] b, logic has, logic fin);
        int gap;
        gap = sender_fast ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= has;
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Send a message of the given length; end it on the last byte or on its own item.
    task automatic send_message(int len);
        bit end_on_byte;
        end_on_byte = (len > 0) && $urandom_range(0, 1);
        for (int i = 0; i < len; i++) begin
            // drop in a neither-flag item now and then
            if ($urandom_range(0, 9) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (i == len - 1));
        end
        if (!end_on_byte) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // Receiver: random stall per result, bursts with no stall, and one long hold-off
    // while the sender keeps offering so the block backs up and stalls its input.
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            if (!long_hold_done && items_sent >= 60) begin
                long_hold_done = 1;
                m_axis_tready <= 1'b0;
                repeat (600) @(negedge i_clk);
            end else begin
                n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
                if (n > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (n) @(negedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    // Watchdog on cycles with no transfer on either side.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int r, len;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty message, single extreme bytes ending the message,
        // a neither-flag item, a byte then a separate end item.
        send_item(8'hff, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h5a, 1'b0, 1'b0);
        send_item(8'ha5, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);

        // Random messages; some lengths sit on the padding boundaries.
        while (items_sent < ItemTarget) begin
            sender_fast = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 9);
            case (r)
                0: len = 55;
                1: len = 56;
                2: len = 63 + $urandom_range(0, 1);
                3: len = 119 + $urandom_range(0, 1);
                default: len = $urandom_range(0, 40);
            endcase
            send_message(len);
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
